### rtl/fpmc_pkg.sv
// fpmc_pkg: shared types and helpers for the Fenwick prefix max/count block.
// Holds the input/result word structs, the node word layout and saturating add.
// No dependencies.
package fpmc_pkg;

    localparam int LEN_W = 16;
    localparam int CNT_W = 48;
    localparam int POS_W = 10;
    localparam int TAG_W = 16;

    localparam logic [TAG_W-1:0] GEN_FIRST = 16'h0001;
    localparam logic [TAG_W-1:0] GEN_LAST  = 16'hFFFF;
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t             command;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] new_length;
        logic [CNT_W-1:0] new_count;
    } in_word_t;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] best_length;
        logic [CNT_W-1:0] best_count;
    } out_word_t;

    // One tree node as stored in memory
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] count;
    } node_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

### rtl/fpmc_node_ram.sv
// fpmc_node_ram: simple dual-port node memory, one write and one read port.
// Read data is registered. Uses fpmc_pkg::node_t.
module fpmc_node_ram
    import fpmc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  node_t                    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output node_t                    rd_data
);

    node_t node_mem [DEPTH];
    node_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/fpmc_engine.sv
// fpmc_engine: command sequencer that walks Fenwick nodes through the node memory,
// folds query results, does read-modify-write merges and sweeps tags after reset and on clear wrap.
// Depends on fpmc_pkg.
module fpmc_engine
    import fpmc_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_word_t                   s_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output out_word_t                  res_data,
    output logic                       mem_wr_en,
    output logic [$clog2(ENTRIES)-1:0] mem_wr_addr,
    output node_t                      mem_wr_data,
    output logic                       mem_rd_en,
    output logic [$clog2(ENTRIES)-1:0] mem_rd_addr,
    input  node_t                      mem_rd_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int IW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t            state_reg,    state_next;
    logic [IW-1:0]     idx_reg,      idx_next;
    logic [AW-1:0]     clr_idx_reg,  clr_idx_next;
    logic [TAG_W-1:0]  gen_reg,      gen_next;
    logic              query_reg,    query_next;
    logic              pend_reg,     pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [LEN_W-1:0]  len_reg,      len_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic              found_reg,    found_next;
    logic [LEN_W-1:0]  best_reg,     best_next;
    logic [CNT_W-1:0]  ways_reg,     ways_next;

    logic [IW-1:0]     low_bit;
    logic [IW-1:0]     idx_down;
    logic [IW:0]       idx_up;
    logic              walk_last;
    logic [31:0]       pos_wide;
    logic              pos_in_range;
    logic [IW-1:0]     start_idx;
    logic              tag_live;
    logic              accept;

    // node index arithmetic
    assign low_bit   = idx_reg & (~idx_reg + IW'(1));
    assign idx_down  = idx_reg - low_bit;
    assign idx_up    = {1'b0, idx_reg} + {1'b0, low_bit};
    assign walk_last = query_reg ? (idx_down == '0) : (idx_up > (IW+1)'(ENTRIES));

    // first node of a walk; queries past the tree saturate to the last node
    assign pos_wide     = 32'(s_data.position);
    assign pos_in_range = pos_wide < 32'(ENTRIES);
    assign start_idx    = pos_in_range ? IW'(pos_wide + 32'd1) : IW'(ENTRIES);

    assign tag_live = (mem_rd_data.tag == gen_reg);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;

    // memory read: one node per walk cycle
    assign mem_rd_en   = (state_reg == ST_WALK);
    assign mem_rd_addr = AW'(idx_reg - IW'(1));

    // memory write: tag sweep, or merge of the node read last cycle
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = pend_addr_reg;
        mem_wr_data = '0;
        if (state_reg == ST_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_reg;
        end else if (pend_reg && !query_reg) begin
            mem_wr_data.tag = gen_reg;
            if (!tag_live || len_reg > mem_rd_data.length) begin
                mem_wr_en          = 1'b1;
                mem_wr_data.length = len_reg;
                mem_wr_data.count  = cnt_reg;
            end else if (len_reg == mem_rd_data.length) begin
                mem_wr_en          = 1'b1;
                mem_wr_data.length = mem_rd_data.length;
                mem_wr_data.count  = sat_add(mem_rd_data.count, cnt_reg);
            end
        end
    end

    // next-state logic
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        clr_idx_next   = clr_idx_reg;
        gen_next       = gen_reg;
        query_next     = query_reg;
        pend_next      = (state_reg == ST_WALK);
        pend_addr_next = mem_rd_addr;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        ways_next      = ways_reg;

        // fold the node read last cycle into the running query result
        if (pend_reg && query_reg && tag_live) begin
            if (!found_reg || mem_rd_data.length > best_reg) begin
                found_next = 1'b1;
                best_next  = mem_rd_data.length;
                ways_next  = mem_rd_data.count;
            end else if (mem_rd_data.length == best_reg) begin
                ways_next = sat_add(ways_reg, mem_rd_data.count);
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    len_next = s_data.new_length;
                    cnt_next = s_data.new_count;
                    case (s_data.command)
                        CMD_QUERY: begin
                            idx_next   = start_idx;
                            query_next = 1'b1;
                            found_next = 1'b0;
                            best_next  = '0;
                            ways_next  = '0;
                            state_next = ST_WALK;
                        end
                        CMD_UPDATE: begin
                            if (pos_in_range) begin
                                idx_next   = start_idx;
                                query_next = 1'b0;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            if (gen_reg == GEN_LAST) begin
                                gen_next     = GEN_FIRST;
                                clr_idx_next = '0;
                                state_next   = ST_CLEAR;
                            end else begin
                                gen_next = gen_reg + TAG_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                idx_next = query_reg ? idx_down : idx_up[IW-1:0];
                if (walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = query_reg ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            gen_reg     <= GEN_FIRST;
            pend_reg    <= 1'b0;
            query_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            gen_reg     <= gen_next;
            pend_reg    <= pend_next;
            query_reg   <= query_next;
        end
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        len_reg       <= len_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        ways_reg      <= ways_next;
    end

    assign res_valid            = (state_reg == ST_RESULT);
    assign res_data.found       = found_reg;
    assign res_data.best_length = best_reg;
    assign res_data.best_count  = ways_reg;

    // checks
    a_no_same_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("node read and write hit the same entry");

    a_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_reg != '0)
        else $error("generation reached zero");

    a_pend_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(mem_rd_en))
        else $error("node data consumed without a read");

    a_sweep_writes_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (mem_wr_en && mem_wr_data.tag == '0))
        else $error("tag sweep wrote a live tag");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg || res_valid) |-> !s_ready)
        else $error("word accepted while a walk is in flight");

endmodule

### rtl/fenwick_prefix_max_count.sv
// fenwick_prefix_max_count: top level; node memory, walk engine and result register.
// Depends on fpmc_pkg, fpmc_node_ram and fpmc_engine.
//
//   channel | ports                      | word        | moves
//   input   | s_valid, s_ready, s_data   | in_word_t   | query / update / clear
//   result  | m_valid, m_ready, m_data   | out_word_t  | one word per query
//
// A walk reads the n tree nodes on its path (at most log2(ENTRIES)+1), one node per
// cycle from the node memory, then drains; a query then also presents its result.
// A clear steps the generation tag; on generation wrap it adds a sweep of all ENTRIES tags.
// After reset the same sweep runs before s_ready rises.
// The result register lets the engine take the next word while a result waits on m_ready.
module fenwick_prefix_max_count
    import fpmc_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = $clog2(ENTRIES);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    node_t         mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    node_t         mem_rd_data;

    logic          res_valid;
    logic          res_ready;
    out_word_t     res_data;

    logic          m_valid_reg;
    out_word_t     m_data_reg;

    fpmc_node_ram #(
        .DEPTH (ENTRIES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fpmc_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // result register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
